// File: hdl/text_console_cursor_ansi_color_unit_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor unit: assertion macros
// Shared concurrent assertion forms for the checker of the console unit.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ANSI_COLOR_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ANSI_COLOR_UNIT_DEFINES_SVH

// check a property outside reset
`define TCC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// check a property at every edge, reset included
`define TCC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// File: hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, constants and command types shared by the console unit modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

    localparam int ESCAPE_DEPTH = 8;
    localparam int TAB_WIDTH    = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int DRAW_CNT_W = $clog2(TAB_WIDTH + 1);

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 9;
    localparam int ROW_W     = 8;
    localparam int GEOM_W    = 8;
    localparam int GLYPH_W   = 7;
    localparam int PEN_W     = 3;
    localparam int ESC_CNT_W = 4;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'h20;
    localparam logic [GLYPH_W-1:0] GLYPH_DEL   = 7'h7f;

    typedef struct packed {
        logic                  col_dec;
        logic                  col_clr;
        logic                  newline;
        logic [DRAW_CNT_W-1:0] ndraw;
        logic [GLYPH_W-1:0]    glyph;
        logic                  pen_wr;
        logic [PEN_W-1:0]      pen_val;
    } cmd_t;

    typedef struct packed {
        logic [GEOM_W-1:0] text_columns;
        logic [GEOM_W-1:0] text_rows;
    } geom_t;

endpackage

`default_nettype wire

// File: hdl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Accepts character beats, runs the escape color parser and classifies each
// character into a cursor command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front
    import tcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              parser_enable,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic              q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1b;

    localparam logic [GLYPH_W-1:0] GLYPH_LBRACKET = 7'h5b;
    localparam logic [GLYPH_W-1:0] GLYPH_M        = 7'h6d;
    localparam logic [GLYPH_W-1:0] GLYPH_ZERO     = 7'h30;

    localparam logic [ACC_W-1:0] PEN_CODE_LO = 32'd30;
    localparam logic [ACC_W-1:0] PEN_CODE_HI = 32'd37;

    logic                 esc_active_reg, esc_active_next;
    logic                 toggle_reg, toggle_next;
    logic [ESC_CNT_W-1:0] esc_cnt_reg, esc_cnt_next;
    logic                 bracket_reg, bracket_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;

    logic                 accept;
    logic                 drop;
    logic                 start;
    logic                 parsing;
    logic [GLYPH_W-1:0]   g;
    logic                 col_dec;
    logic                 col_clr;
    logic                 newline;
    logic [DRAW_CNT_W-1:0] ndraw;
    logic [ESC_CNT_W-1:0] pos;
    logic [ESC_CNT_W-1:0] pos_p1;
    logic [ACC_W-1:0]     acc_base;
    logic [ACC_W-1:0]     acc_step;
    logic                 bracket_upd;
    logic                 pen_wr;
    logic [PEN_W-1:0]     pen_val;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        g       = char_code[GLYPH_W-1:0];
        drop    = 1'b0;
        start   = 1'b0;
        col_dec = 1'b0;
        col_clr = 1'b0;
        newline = 1'b0;
        ndraw   = '0;
        case (char_code)
            CH_NUL:
            begin
                g = '0;
            end
            CH_BS:
            begin
                g       = GLYPH_SPACE;
                col_dec = 1'b1;
                ndraw   = DRAW_CNT_W'(1);
            end
            CH_CR:
            begin
                col_clr = 1'b1;
            end
            CH_LF:
            begin
                newline = 1'b1;
            end
            CH_TAB:
            begin
                g     = GLYPH_SPACE;
                ndraw = DRAW_CNT_W'(TAB_WIDTH);
            end
            CH_ESC:
            begin
                if (parser_enable)
                begin
                    start = 1'b1;
                end
                else
                begin
                    g     = GLYPH_SPACE;
                    ndraw = DRAW_CNT_W'(1);
                end
            end
            default:
            begin
                drop  = (g < GLYPH_SPACE) || (g == GLYPH_DEL);
                ndraw = DRAW_CNT_W'(1);
            end
        endcase
    end

    assign parsing  = parser_enable && (start || esc_active_reg);
    assign pos      = start ? '0 : esc_cnt_reg;
    assign pos_p1   = pos + ESC_CNT_W'(1);
    assign acc_base = start ? '0 : acc_reg;
    assign acc_step = (acc_base << 3) + (acc_base << 1) + ACC_W'(g) - ACC_W'(GLYPH_ZERO);

    always_comb
    begin
        bracket_upd = start ? 1'b0 : bracket_reg;
        if (pos == ESC_CNT_W'(1))
        begin
            bracket_upd = (g == GLYPH_LBRACKET);
        end
    end

    always_comb
    begin
        pen_val = '0;
        if (acc_base inside {[PEN_CODE_LO:PEN_CODE_HI]})
        begin
            pen_val = PEN_W'(acc_base - PEN_CODE_LO);
        end
    end

    assign pen_wr = (g == GLYPH_M) && bracket_upd && !toggle_reg;

    always_comb
    begin
        esc_active_next = esc_active_reg;
        toggle_next     = toggle_reg;
        esc_cnt_next    = esc_cnt_reg;
        bracket_next    = bracket_reg;
        acc_next        = acc_reg;
        if (accept && !drop && parsing)
        begin
            esc_cnt_next = pos_p1;
            bracket_next = bracket_upd;
            acc_next     = acc_base;
            if ((pos >= ESC_CNT_W'(2)) && (g != GLYPH_M))
            begin
                acc_next = acc_step;
            end
            if (g == GLYPH_M)
            begin
                esc_active_next = 1'b0;
                toggle_next     = !toggle_reg;
            end
            else if (pos_p1 == ESC_CNT_W'(ESCAPE_DEPTH))
            begin
                esc_active_next = 1'b0;
                toggle_next     = 1'b0;
            end
            else
            begin
                esc_active_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        q_cmd = '0;
        if (parsing)
        begin
            q_cmd.col_dec = col_dec;
            q_cmd.col_clr = col_clr;
            q_cmd.pen_wr  = pen_wr;
            q_cmd.pen_val = pen_val;
            q_push        = accept && !drop && (col_dec || col_clr || pen_wr);
        end
        else
        begin
            q_cmd.col_dec = col_dec;
            q_cmd.col_clr = col_clr;
            q_cmd.newline = newline;
            q_cmd.ndraw   = ndraw;
            q_cmd.glyph   = g;
            q_push        = accept && !drop &&
                            (col_dec || col_clr || newline || (ndraw != '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_active_reg <= 1'b0;
            toggle_reg     <= 1'b0;
            esc_cnt_reg    <= '0;
            bracket_reg    <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            esc_active_reg <= esc_active_next;
            toggle_reg     <= toggle_next;
            esc_cnt_reg    <= esc_cnt_next;
            bracket_reg    <= bracket_next;
            acc_reg        <= acc_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tcc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// tcc_cmd_fifo
// Short command queue between the classifier front and the cursor back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_cmd_fifo
    import tcc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      empty
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/tcc_back.sv
// ----------------------------------------------------------------------------
// tcc_back
// Cursor sequencer: pops commands, moves the cursor, draws one cell per cycle
// while the output register is free and raises scroll beats on the last row.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_back
    import tcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire geom_t             geom,
    input  wire logic              q_empty,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic [COL_W-1:0]       cell_column,
    output logic [ROW_W-1:0]       cell_row,
    output logic [GLYPH_W-1:0]     glyph,
    output logic [PEN_W-1:0]       color_index,
    output logic                   last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_END
    } state_t;

    state_t                state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [PEN_W-1:0]      pen_reg, pen_next;
    logic [GLYPH_W-1:0]    glyph_reg, glyph_next;
    logic [DRAW_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  line_end_reg, line_end_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  kind_reg, kind_next;
    logic [COL_W-1:0]      cell_column_reg, cell_column_next;
    logic [ROW_W-1:0]      cell_row_reg, cell_row_next;
    logic [GLYPH_W-1:0]    out_glyph_reg, out_glyph_next;
    logic [PEN_W-1:0]      color_reg, color_next;
    logic                  last_reg, last_next;

    logic                  slot_free;
    logic [COL_W:0]        col_p1;
    logic [ROW_W:0]        row_p1;
    logic                  col_hit;
    logic                  row_ok;
    logic                  le;
    logic                  le_after;

    assign slot_free = !out_valid_reg || out_ready;
    assign col_p1    = {1'b0, col_reg} + 1'b1;
    assign row_p1    = {1'b0, row_reg} + 1'b1;
    assign col_hit   = (col_p1 >= (COL_W + 1)'(geom.text_columns));
    assign row_ok    = (row_p1 < (ROW_W + 1)'(geom.text_rows));
    assign le        = line_end_reg || col_hit;
    assign le_after  = le && !row_ok;

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pen_next         = pen_reg;
        glyph_next       = glyph_reg;
        cnt_next         = cnt_reg;
        line_end_next    = line_end_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        kind_next        = kind_reg;
        cell_column_next = cell_column_reg;
        cell_row_next    = cell_row_reg;
        out_glyph_next   = out_glyph_reg;
        color_next       = color_reg;
        last_next        = last_reg;
        q_pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.col_dec)
                    begin
                        col_next = (col_reg == '0) ? '0 : col_reg - 1'b1;
                    end
                    else if (q_cmd.col_clr)
                    begin
                        col_next = '0;
                    end
                    if (q_cmd.pen_wr)
                    begin
                        pen_next = q_cmd.pen_val;
                    end
                    glyph_next    = q_cmd.glyph;
                    cnt_next      = q_cmd.ndraw;
                    line_end_next = q_cmd.newline;
                    if (q_cmd.ndraw != '0)
                    begin
                        state_next = ST_DRAW;
                    end
                    else if (q_cmd.newline)
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_DRAW:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = KIND_DRAW;
                    cell_column_next = col_reg;
                    cell_row_next    = row_reg;
                    out_glyph_next   = glyph_reg;
                    color_next       = pen_reg;
                    last_next        = (cnt_reg == DRAW_CNT_W'(1)) && !le_after;
                    if (le && row_ok)
                    begin
                        col_next = '0;
                        row_next = row_p1[ROW_W-1:0];
                    end
                    else
                    begin
                        col_next = col_p1[COL_W-1:0];
                    end
                    line_end_next = le_after;
                    cnt_next      = cnt_reg - 1'b1;
                    if (cnt_reg == DRAW_CNT_W'(1))
                    begin
                        state_next = le_after ? ST_END : ST_IDLE;
                    end
                end
            end
            ST_END:
            begin
                if (row_ok)
                begin
                    row_next      = row_p1[ROW_W-1:0];
                    pen_next      = '0;
                    col_next      = '0;
                    line_end_next = 1'b0;
                    state_next    = ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = KIND_SCROLL;
                    cell_column_next = '0;
                    cell_row_next    = '0;
                    out_glyph_next   = '0;
                    color_next       = '0;
                    last_next        = 1'b1;
                    col_next         = '0;
                    line_end_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            col_reg         <= '0;
            row_reg         <= '0;
            pen_reg         <= '0;
            glyph_reg       <= '0;
            cnt_reg         <= '0;
            line_end_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= KIND_DRAW;
            cell_column_reg <= '0;
            cell_row_reg    <= '0;
            out_glyph_reg   <= '0;
            color_reg       <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            pen_reg         <= pen_next;
            glyph_reg       <= glyph_next;
            cnt_reg         <= cnt_next;
            line_end_reg    <= line_end_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            cell_column_reg <= cell_column_next;
            cell_row_reg    <= cell_row_next;
            out_glyph_reg   <= out_glyph_next;
            color_reg       <= color_next;
            last_reg        <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign cell_column = cell_column_reg;
    assign cell_row    = cell_row_reg;
    assign glyph       = out_glyph_reg;
    assign color_index = color_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// File: hdl/text_console_cursor_ansi_color_unit.sv
// ----------------------------------------------------------------------------
// text_console_cursor_ansi_color_unit
// Text console cursor with an escape color parser: characters in, glyph draw
// and scroll beats out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | to unit   | in_valid / in_ready  | char_code
//   out     | from unit | out_valid / out_ready| kind, cell_column, cell_row,
//           |           |                      | glyph, color_index, last
//   cfg     | to unit   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The front takes one character per cycle into a two-entry command queue
// while the queue is not full. The back sequencer pops a command only in
// its idle state and issues every result beat of that command before it
// pops the next. Reset is asynchronous and takes effect at once; no
// clearing pass follows. A stalled out channel holds the output register;
// the queue then fills and drops in_ready. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_ansi_color_unit
    import tcc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CHAR_W-1:0]    char_code,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic [COL_W-1:0]          cell_column,
    output logic [ROW_W-1:0]          cell_row,
    output logic [GLYPH_W-1:0]        glyph,
    output logic [PEN_W-1:0]          color_index,
    output logic                      last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GEOM_W-1:0]    cfg_data
);

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARSER_ENABLE = 2'd2;

    localparam logic [GEOM_W-1:0] COLUMNS_RESET = 8'd100;
    localparam logic [GEOM_W-1:0] ROWS_RESET    = 8'd30;

    geom_t geom_reg, geom_next;
    logic  parser_en_reg, parser_en_next;

    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    cmd_t  push_cmd;
    cmd_t  pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        geom_next      = geom_reg;
        parser_en_next = parser_en_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TEXT_COLUMNS:  geom_next.text_columns = cfg_data;
                CFG_TEXT_ROWS:     geom_next.text_rows    = cfg_data;
                CFG_PARSER_ENABLE: parser_en_next         = cfg_data[0];
                default:           parser_en_next         = parser_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.text_columns <= COLUMNS_RESET;
            geom_reg.text_rows    <= ROWS_RESET;
            parser_en_reg         <= 1'b1;
        end
        else
        begin
            geom_reg      <= geom_next;
            parser_en_reg <= parser_en_next;
        end
    end

    tcc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .parser_enable (parser_en_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    tcc_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tcc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom_reg),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .glyph       (glyph),
        .color_index (color_index),
        .last        (last)
    );

endmodule

`default_nettype wire

// File: hdl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the console unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_ansi_color_unit_defines.svh"

module tcc_checker
    import tcc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic [CHAR_W-1:0]    char_code,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 kind,
    input wire logic [COL_W-1:0]     cell_column,
    input wire logic [ROW_W-1:0]     cell_row,
    input wire logic [GLYPH_W-1:0]   glyph,
    input wire logic [PEN_W-1:0]     color_index,
    input wire logic                 last,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [GEOM_W-1:0]    cfg_data
);

    logic unused_ok;

    assign unused_ok = ^{in_valid, in_ready, char_code, cfg_valid, cfg_ready,
                         cfg_index, cfg_data};

    `TCC_ASSERT_RST(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(cell_column)
            && $stable(cell_row) && $stable(glyph) && $stable(color_index)
            && $stable(last),
        "stalled result beat changed")
    `TCC_ASSERT_RST(a_scroll_clean, clk, rst_n,
        out_valid && (kind == KIND_SCROLL) |-> (cell_column == '0) && (cell_row == '0)
            && (glyph == '0) && (color_index == '0) && last,
        "scroll beat carries cell data or is not last")
    `TCC_ASSERT_RST(a_draw_printable, clk, rst_n,
        out_valid && (kind == KIND_DRAW) |-> (glyph >= GLYPH_SPACE) && (glyph != GLYPH_DEL),
        "draw beat with a control glyph")
    `TCC_ASSERT_ALL(a_reset_quiet, clk, !rst_n |=> !out_valid,
        "result beat offered after reset")

endmodule

bind text_console_cursor_ansi_color_unit tcc_checker u_tcc_checker (.*);

`default_nettype wire

// File: verif/tcc_console_checker.sv
// ----------------------------------------------------------------------------
// Console unit checker
// Watches the character, result and register channels of the console unit,
// keeps its own cursor, pen and escape parser, predicts the draw and scroll
// beats for every character taken and compares the outgoing beats in order.
// ----------------------------------------------------------------------------
package tcc_tb_pkg;
    import tcc_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_COLUMNS,
        REG_TEXT_ROWS,
        REG_PARSER_ENABLE,
        REG_SPARE
    } cfg_reg_e;

    localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1b;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5b;
    localparam logic [CHAR_W-1:0] CH_M        = 8'h6d;
    localparam logic [CHAR_W-1:0] CH_DEL      = 8'h7f;

    localparam int SGR_FG_FIRST = 30;
    localparam int SGR_FG_LAST  = 37;
endpackage

module tcc_console_checker
    import tcc_pkg::*, tcc_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 kind,
    input  logic [COL_W-1:0]     cell_column,
    input  logic [ROW_W-1:0]     cell_row,
    input  logic [GLYPH_W-1:0]   glyph,
    input  logic [PEN_W-1:0]     color_index,
    input  logic                 last,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GEOM_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending_beats,
    output int                   beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               kind;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [GLYPH_W-1:0] glyph;
        logic [PEN_W-1:0]   color;
        logic               last;
    } console_beat_t;

    console_beat_t expected_beats [$];

    logic [GEOM_W-1:0]    text_cols;
    logic [GEOM_W-1:0]    text_rows;
    logic                 parse_en;
    logic [COL_W-1:0]     cur_col;
    logic [ROW_W-1:0]     cur_row;
    logic [PEN_W-1:0]     pen;
    logic                 esc_active;
    logic                 finish_flip;
    logic [ESC_CNT_W-1:0] esc_count;
    logic                 bracket;
    logic [ACC_W-1:0]     code_acc;
    int                   mismatches = 0;
    int                   checked = 0;

    task automatic feed_parser(input logic [GLYPH_W-1:0] g);
        logic [ESC_CNT_W-1:0] pos;
        pos = esc_count;
        esc_count = esc_count + 1'b1;
        if (pos == 1)
            bracket = (g == CH_LBRACKET[GLYPH_W-1:0]);
        else if (pos >= 2 && g != CH_M[GLYPH_W-1:0])
            code_acc = code_acc * 32'd10 + {25'd0, g} - {24'd0, CH_ZERO};
        if (g == CH_M[GLYPH_W-1:0])
        begin
            if (bracket && !finish_flip)
                pen = (code_acc >= SGR_FG_FIRST && code_acc <= SGR_FG_LAST)
                    ? PEN_W'(code_acc - 32'(SGR_FG_FIRST)) : '0;
            esc_active = 1'b0;
            finish_flip = !finish_flip;
        end
        else if (esc_count == ESC_CNT_W'(ESCAPE_DEPTH))
        begin
            esc_active = 1'b0;
            finish_flip = 1'b0;
        end
    endtask

    task automatic console_advance(input logic [CHAR_W-1:0] c);
        logic [GLYPH_W-1:0] g;
        int                 ndraw;
        int                 first;
        int                 k;
        logic               line_end;
        logic               dropped;
        console_beat_t      b;
        g = '0;
        ndraw = 0;
        line_end = 1'b0;
        dropped = 1'b0;
        first = expected_beats.size();
        case (c)
            CH_NUL: g = '0;
            CH_BS:
            begin
                if (cur_col != 0)
                    cur_col = cur_col - 1'b1;
                g = GLYPH_SPACE;
                ndraw = 1;
            end
            CH_CR:
            begin
                cur_col = '0;
                g = CH_CR[GLYPH_W-1:0];
            end
            CH_LF:
            begin
                g = CH_LF[GLYPH_W-1:0];
                line_end = 1'b1;
            end
            CH_TAB:
            begin
                g = GLYPH_SPACE;
                ndraw = TAB_WIDTH;
            end
            CH_ESC:
            begin
                if (parse_en)
                begin
                    esc_active = 1'b1;
                    esc_count = '0;
                    code_acc = '0;
                    bracket = 1'b0;
                    g = CH_ESC[GLYPH_W-1:0];
                end
                else
                begin
                    g = GLYPH_SPACE;
                    ndraw = 1;
                end
            end
            default:
            begin
                g = c[GLYPH_W-1:0];
                dropped = (g < 7'd32 || g == GLYPH_DEL);
                ndraw = 1;
            end
        endcase
        if (dropped)
            return;
        if (parse_en && esc_active)
        begin
            feed_parser(g);
            return;
        end
        for (k = 0; k < ndraw; k++)
        begin
            if (int'(cur_col) + 1 >= int'(text_cols))
                line_end = 1'b1;
            b = '{KIND_DRAW, cur_col, cur_row, g, pen, 1'b0};
            expected_beats.push_back(b);
            cur_col = cur_col + 1'b1;
            if (line_end && int'(cur_row) + 1 < int'(text_rows))
            begin
                line_end = 1'b0;
                cur_col = '0;
                cur_row = cur_row + 1'b1;
            end
        end
        if (line_end)
        begin
            if (int'(cur_row) + 1 >= int'(text_rows))
            begin
                b = '{KIND_SCROLL, '0, '0, '0, '0, 1'b0};
                expected_beats.push_back(b);
            end
            else
            begin
                cur_row = cur_row + 1'b1;
                pen = '0;
            end
            cur_col = '0;
        end
        if (expected_beats.size() > first)
        begin
            b = expected_beats.pop_back();
            b.last = 1'b1;
            expected_beats.push_back(b);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        console_beat_t seen;
        console_beat_t want;
        if (!rst_n)
        begin
            text_cols <= 8'd100;
            text_rows <= 8'd30;
            parse_en <= 1'b1;
            cur_col <= '0;
            cur_row <= '0;
            pen <= '0;
            esc_active <= 1'b0;
            finish_flip <= 1'b0;
            esc_count <= '0;
            bracket <= 1'b0;
            code_acc <= '0;
            expected_beats.delete();
            fail_count <= 0;
            pending_beats <= 0;
            beats_checked <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = '{kind, cell_column, cell_row, glyph, color_index, last};
                checked++;
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: beat with nothing expected: kind=%0d col=%0d row=%0d glyph=%02h color=%0d last=%0d",
                             $time, seen.kind, seen.column, seen.row, seen.glyph,
                             seen.color, seen.last);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        $display("%0t: beat mismatch: expected kind=%0d col=%0d row=%0d glyph=%02h color=%0d last=%0d",
                                 $time, want.kind, want.column, want.row, want.glyph,
                                 want.color, want.last);
                        $display("%0t:                actual   kind=%0d col=%0d row=%0d glyph=%02h color=%0d last=%0d",
                                 $time, seen.kind, seen.column, seen.row, seen.glyph,
                                 seen.color, seen.last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_e'(cfg_index))
                    REG_TEXT_COLUMNS:  text_cols = cfg_data;
                    REG_TEXT_ROWS:     text_rows = cfg_data;
                    REG_PARSER_ENABLE: parse_en = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                console_advance(char_code);
            fail_count <= mismatches;
            pending_beats <= expected_beats.size();
            beats_checked <= checked;
        end
    end
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Console unit testbench
// Drives characters and register writes into the console unit under several
// geometries, parser settings and idle patterns, with a long output hold-off,
// and leaves prediction and comparison of every beat to the checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*, tcc_tb_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CHAR_W-1:0]    char_code = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 kind;
    logic [COL_W-1:0]     cell_column;
    logic [ROW_W-1:0]     cell_row;
    logic [GLYPH_W-1:0]   glyph;
    logic [PEN_W-1:0]     color_index;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GEOM_W-1:0]    cfg_data = '0;

    int fail_count;
    int pending_beats;
    int beats_checked;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int chars_sent = 0;
    int chars_counted = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    bit hold_req = 1'b0;
    bit hold_ack = 1'b0;

    logic [CHAR_W-1:0] opening_chars [24] = '{
        8'h41, 8'h20, 8'h7e, CH_DEL, 8'hff, 8'hc1, 8'h01, CH_NUL,
        CH_TAB, CH_BS, CH_CR, CH_LF,
        CH_ESC, CH_LBRACKET, 8'h33, 8'h31, CH_M, 8'h58,
        CH_ESC, CH_LBRACKET, 8'h33, 8'h32, CH_M, 8'h59
    };

    text_console_cursor_ansi_color_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .cell_column (cell_column),
        .cell_row    (cell_row),
        .glyph       (glyph),
        .color_index (color_index),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    tcc_console_checker console_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .cell_column   (cell_column),
        .cell_row      (cell_row),
        .glyph         (glyph),
        .color_index   (color_index),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .beats_checked (beats_checked)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        if ((c inside {CH_NUL, CH_BS, CH_TAB, CH_LF, CH_CR, CH_ESC})
            || (c[GLYPH_W-1:0] >= 7'd32 && c[GLYPH_W-1:0] != GLYPH_DEL))
            chars_counted++;
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [GEOM_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [GEOM_W-1:0] cols, input logic [GEOM_W-1:0] rows,
                                input logic en);
        write_reg(REG_TEXT_COLUMNS, cols);
        write_reg(REG_TEXT_ROWS, rows);
        write_reg(REG_PARSER_ENABLE, {7'($urandom_range(0, 127)), en});
    endtask

    task automatic send_unit();
        int pick;
        int len;
        int r;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_char({($urandom_range(0, 4) == 0), 7'($urandom_range(32, 126))});
        else if (pick < 60)
        begin
            // color sequence, mostly well formed
            send_char(CH_ESC);
            send_char(($urandom_range(0, 7) == 0) ? 8'($urandom_range(32, 126)) : CH_LBRACKET);
            if ($urandom_range(0, 3) != 0)
            begin
                send_char(CH_ZERO + 8'd3);
                send_char(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            else
            begin
                len = $urandom_range(1, 3);
                repeat (len) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            send_char(CH_M);
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 4))
                0: send_char(CH_NUL);
                1: send_char(CH_BS);
                2: send_char(CH_TAB);
                3: send_char(CH_LF);
                default: send_char(CH_CR);
            endcase
        end
        else if (pick < 85)
        begin
            // broken sequence: restarts, overflow, controls inside
            send_char(CH_ESC);
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_char(CH_ESC);
                else if (r < 3)
                    send_char(8'($urandom_range(0, 31)));
                else
                    send_char(8'($urandom_range(32, 126)));
            end
        end
        else
            send_char(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random(input int count);
        int target;
        target = chars_counted + count;
        while (chars_counted < target)
            send_unit();
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_chars[i])
            send_char(opening_chars[i]);
        settle();

        set_geometry(8'd8, 8'd3, 1'b1);
        hold_req = ~hold_req;
        send_random(25);
        settle();

        set_geometry(8'd255, 8'd255, 1'b1);
        send_idle_pct = 75;
        send_random(15);
        // leave a sequence open across the parser switch-off
        send_char(CH_ESC);
        send_char(CH_LBRACKET);
        send_char(CH_ZERO + 8'd3);
        settle();

        set_geometry(8'd2, 8'd1, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        send_random(20);
        settle();

        set_geometry(8'd5, 8'd4, 1'b1);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_random(12);
        settle();
        send_random(12);
        settle();

        write_reg(REG_TEXT_COLUMNS, 8'd1);
        write_reg(REG_TEXT_ROWS, 8'd0);
        send_random(6);
        settle();
        write_reg(REG_TEXT_COLUMNS, 8'd0);
        write_reg(REG_TEXT_ROWS, 8'd2);
        write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(6);
        settle();

        $display("covered: %0d characters, %0d result beats, %0d register writes",
                 chars_sent, beats_checked, cfg_writes);
        $display("  over 0..255 columns and rows, parser on and off, long output hold-off");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_front.sv
hdl/tcc_cmd_fifo.sv
hdl/tcc_back.sv
hdl/text_console_cursor_ansi_color_unit.sv
hdl/tcc_checker.sv
verif/tcc_console_checker.sv
verif/tb.sv
